/* rtl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Type codes, pipeline beat types and helpers for the numeric type cast.
// ----------------------------------------------------------------------------
package ntc_pkg;

  typedef enum logic [3:0] {
    TY_U8  = 4'd0,
    TY_S8  = 4'd1,
    TY_U16 = 4'd2,
    TY_S16 = 4'd3,
    TY_U32 = 4'd4,
    TY_S32 = 4'd5,
    TY_U64 = 4'd6,
    TY_S64 = 4'd7,
    TY_F32 = 4'd8,
    TY_F64 = 4'd9
  } type_e;

  typedef enum logic [1:0] {
    MODE_ZERO,    // unused type code: result zero
    MODE_PASS,    // result fully formed in decode
    MODE_TO_FLT,  // round to binary32 / binary64
    MODE_TO_INT   // truncate and saturate to integer
  } mode_e;

  localparam logic CFG_SRC = 1'b0;
  localparam logic CFG_DST = 1'b1;

  // decode / normalize beat: value = mant * 2^(exp - 63)
  typedef struct packed {
    logic        valid;
    logic        last;
    mode_e       mode;
    logic [3:0]  dst;
    logic        sign;
    logic        zero;
    logic [12:0] exp;
    logic [63:0] mant;
    logic [63:0] bits;
    logic        flag;
  } norm_t;

  // aligned beat: q is the kept part, rnd / stk the guard and sticky bits
  typedef struct packed {
    logic        valid;
    logic        last;
    mode_e       mode;
    logic [3:0]  dst;
    logic        sign;
    logic        zero;
    logic        sub;
    logic [12:0] exp;
    logic [63:0] q;
    logic        rnd;
    logic        stk;
    logic [63:0] bits;
    logic        flag;
  } algn_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [63:0] bits;
    logic        flag;
  } res_t;

  function automatic logic [6:0] int_bits(logic [3:0] t);
    int_bits = 7'd8 << t[2:1];
  endfunction

  function automatic logic [63:0] type_mask(logic [3:0] t);
    logic [63:0] m;
    case (t)
      TY_F32:                 m = 64'h0000_0000_FFFF_FFFF;
      TY_F64, TY_U64, TY_S64: m = '1;
      default:                m = (64'h1 << int_bits(t)) - 64'h1;
    endcase
    type_mask = m;
  endfunction

  // leading zero count, 64 for an all-zero word
  function automatic logic [6:0] lzc64(logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(63 - i);
      end
    end
    lzc64 = n;
  endfunction

endpackage

/* rtl/numeric_type_cast.sv */
// ----------------------------------------------------------------------------
// numeric_type_cast
// Casts one element per beat between u8..s64, binary32 and binary64.
// ----------------------------------------------------------------------------
// Takes one beat every clock and returns its result through the four register
// stages (decode, normalize, align, round/saturate). busy is never raised, and
// result beats carry no back-pressure: result_valid_o marks each beat for one
// cycle. Integers narrow by keeping low bits and widen by sign or zero
// extension; integer to float and binary64 to binary32 round to nearest even;
// float to integer truncates toward zero, saturating out-of-range values and
// mapping NaN to zero, both with out_of_range_o set. The user must write the
// type registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no beat
// is in flight; the block itself does not enforce this.
module numeric_type_cast
  import ntc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits_i,
  input  logic        last_element_i,
  output logic        result_valid_o,
  output logic [63:0] result_bits_o,
  output logic        out_of_range_o,
  output logic        last_out_o
);

  logic [3:0] src_q, dst_q;
  norm_t      s1_d, s1_q, s2_d, s2_q;
  algn_t      s3_d, s3_q;
  res_t       out_d, out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= TY_U8;
      dst_q <= TY_U8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SRC) begin
        src_q <= cfg_wdata_i;
      end else begin
        dst_q <= cfg_wdata_i;
      end
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: decode the source into sign / exponent / mantissa, or form the
  // result directly for int-to-int, same-type, NaN and inf-to-float cases
  // --------------------------------------------------------------------------
  logic [63:0] raw, sxt;
  logic [7:0]  e32;
  logic [10:0] e64;
  logic        nan32, inf32, nan64, inf64;

  always_comb begin
    raw   = value_bits_i & type_mask(src_q);
    sxt   = raw;
    if (src_q < TY_F32 && src_q[0] && raw[6'(int_bits(src_q) - 7'd1)]) begin
      sxt = raw | ~type_mask(src_q);
    end
    e32   = raw[30:23];
    e64   = raw[62:52];
    nan32 = (e32 == 8'hFF) && (raw[22:0] != '0);
    inf32 = (e32 == 8'hFF) && (raw[22:0] == '0);
    nan64 = (e64 == 11'h7FF) && (raw[51:0] != '0);
    inf64 = (e64 == 11'h7FF) && (raw[51:0] == '0);

    s1_d       = '0;
    s1_d.valid = start;
    s1_d.last  = last_element_i;
    s1_d.dst   = dst_q;
    s1_d.mode  = MODE_ZERO;

    if (src_q <= TY_F64 && dst_q <= TY_F64) begin
      if (src_q < TY_F32) begin
        if (dst_q < TY_F32) begin
          s1_d.mode = MODE_PASS;
          s1_d.bits = sxt & type_mask(dst_q);
        end else begin
          s1_d.mode = MODE_TO_FLT;
          s1_d.sign = src_q[0] & sxt[63];
          s1_d.mant = s1_d.sign ? (~sxt + 64'h1) : sxt;
          s1_d.exp  = 13'd63;
        end
      end else if (src_q == dst_q) begin
        s1_d.mode = MODE_PASS;
        s1_d.bits = raw;
      end else if (src_q == TY_F32) begin
        s1_d.sign = raw[31];
        s1_d.mant = {(e32 != '0), raw[22:0], 40'b0};
        s1_d.exp  = 13'((e32 == '0) ? 8'd1 : e32) - 13'd127;
        s1_d.mode = (dst_q == TY_F64) ? MODE_TO_FLT : MODE_TO_INT;
        if (nan32) begin
          s1_d.mode = MODE_PASS;
          if (dst_q == TY_F64) begin
            s1_d.bits = {raw[31], 12'hFFF, raw[21:0], 29'b0};
          end else begin
            s1_d.flag = 1'b1;
          end
        end else if (inf32 && dst_q == TY_F64) begin
          s1_d.mode = MODE_PASS;
          s1_d.bits = {raw[31], 11'h7FF, 52'b0};
        end
      end else begin
        s1_d.sign = raw[63];
        s1_d.mant = {(e64 != '0), raw[51:0], 11'b0};
        s1_d.exp  = 13'((e64 == '0) ? 11'd1 : e64) - 13'd1023;
        s1_d.mode = (dst_q == TY_F32) ? MODE_TO_FLT : MODE_TO_INT;
        if (nan64) begin
          s1_d.mode = MODE_PASS;
          if (dst_q == TY_F32) begin
            s1_d.bits = {32'b0, raw[63], 9'h1FF, raw[50:29]};
          end else begin
            s1_d.flag = 1'b1;
          end
        end else if (inf64 && dst_q == TY_F32) begin
          s1_d.mode = MODE_PASS;
          s1_d.bits = {32'b0, raw[63], 8'hFF, 23'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: normalize so the mantissa MSB sits at bit 63
  // --------------------------------------------------------------------------
  logic [6:0] lz;

  always_comb begin
    lz        = lzc64(s1_q.mant);
    s2_d      = s1_q;
    s2_d.mant = s1_q.mant << lz;
    s2_d.exp  = s1_q.exp - 13'(lz);
    s2_d.zero = (s1_q.mant == '0);
  end

  // --------------------------------------------------------------------------
  // stage 3: align. Float targets keep p bits (fewer when subnormal); integer
  // targets keep the integer part. Guard and sticky fall out of one shifter.
  // --------------------------------------------------------------------------
  logic signed [13:0] exps, shf, dsum;
  logic        [6:0]  dsh;
  logic        [127:0] ext;

  always_comb begin
    exps = $signed({s2_q.exp[12], s2_q.exp});
    shf  = '0;
    s3_d = '0;
    if (s2_q.mode == MODE_TO_FLT) begin
      shf  = (s2_q.dst == TY_F32) ? (-14'sd126 - exps) : (-14'sd1022 - exps);
      dsum = ((s2_q.dst == TY_F32) ? 14'sd40 : 14'sd11) + ((shf > 0) ? shf : 14'sd0);
    end else begin
      dsum = 14'sd63 - exps;
      if (dsum < 0) begin
        dsum = '0;
      end
    end
    dsh = (dsum > 14'sd65) ? 7'd65 : dsum[6:0];
    ext = {s2_q.mant, 64'b0} >> dsh;

    s3_d.valid = s2_q.valid;
    s3_d.last  = s2_q.last;
    s3_d.mode  = s2_q.mode;
    s3_d.dst   = s2_q.dst;
    s3_d.sign  = s2_q.sign;
    s3_d.zero  = s2_q.zero;
    s3_d.sub   = (s2_q.mode == MODE_TO_FLT) && (shf > 0);
    s3_d.exp   = s2_q.exp;
    s3_d.q     = ext[127:64];
    s3_d.rnd   = ext[63];
    s3_d.stk   = |ext[62:0];
    s3_d.bits  = s2_q.bits;
    s3_d.flag  = s2_q.flag;
  end

  // --------------------------------------------------------------------------
  // stage 4: round to nearest even and pack, or saturate to integer.
  // Packing adds the rounded significand onto (biased exponent - 1) so the
  // hidden bit and any rounding carry land in the exponent field.
  // --------------------------------------------------------------------------
  logic signed [12:0] ex;
  logic               inc;
  logic [24:0]        m25;
  logic [53:0]        m54;
  logic [7:0]         eb8;
  logic [10:0]        eb11;
  logic [30:0]        sum31;
  logic [62:0]        sum63;
  logic [6:0]         nb;
  logic [63:0]        half, imask, ival;

  always_comb begin
    ex    = $signed(s3_q.exp);
    inc   = s3_q.rnd & (s3_q.stk | s3_q.q[0]);
    m25   = {1'b0, s3_q.q[23:0]} + 25'(inc);
    m54   = {1'b0, s3_q.q[52:0]} + 54'(inc);
    eb8   = s3_q.sub ? 8'd0 : 8'(s3_q.exp + 13'd126);
    eb11  = s3_q.sub ? 11'd0 : 11'(s3_q.exp + 13'd1022);
    sum31 = {eb8, 23'b0} + {6'b0, m25};
    sum63 = {eb11, 52'b0} + {9'b0, m54};
    nb    = int_bits(s3_q.dst);
    half  = 64'h1 << (nb - 7'd1);
    imask = type_mask(s3_q.dst);
    ival  = (s3_q.sign ? (~s3_q.q + 64'h1) : s3_q.q) & imask;

    out_d       = '0;
    out_d.valid = s3_q.valid;
    out_d.last  = s3_q.last;
    case (s3_q.mode)
      MODE_PASS: begin
        out_d.bits = s3_q.bits;
        out_d.flag = s3_q.flag;
      end
      MODE_TO_FLT: begin
        if (s3_q.dst == TY_F32) begin
          if (s3_q.zero) begin
            out_d.bits = {32'b0, s3_q.sign, 31'b0};
          end else if (!s3_q.sub && ex >= 13'sd128) begin
            out_d.bits = {32'b0, s3_q.sign, 8'hFF, 23'b0};
          end else begin
            out_d.bits = {32'b0, s3_q.sign, sum31};
          end
        end else begin
          if (s3_q.zero) begin
            out_d.bits = {s3_q.sign, 63'b0};
          end else if (!s3_q.sub && ex >= 13'sd1024) begin
            out_d.bits = {s3_q.sign, 11'h7FF, 52'b0};
          end else begin
            out_d.bits = {s3_q.sign, sum63};
          end
        end
      end
      MODE_TO_INT: begin
        out_d.bits = ival;
        if (s3_q.dst[0]) begin
          if (s3_q.sign && (ex >= $signed(13'(nb)) || s3_q.q > half)) begin
            out_d.bits = half;
            out_d.flag = 1'b1;
          end else if (!s3_q.sign && ex >= $signed(13'(nb - 7'd1))) begin
            out_d.bits = half - 64'h1;
            out_d.flag = 1'b1;
          end
        end else begin
          if (s3_q.sign && ex >= 13'sd0) begin
            out_d.bits = '0;
            out_d.flag = 1'b1;
          end else if (!s3_q.sign && ex >= $signed(13'(nb))) begin
            out_d.bits = imask;
            out_d.flag = 1'b1;
          end
        end
      end
      default: begin
        out_d.bits = '0;
        out_d.flag = 1'b0;
      end
    endcase
  end

  // pipeline registers, advancing every clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      out_q <= '0;
    end else begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_q.valid;
  assign result_bits_o  = out_q.bits;
  assign out_of_range_o = out_q.flag;
  assign last_out_o     = out_q.last;

endmodule

/* rtl/ntc_checker.sv */
// ----------------------------------------------------------------------------
// ntc_checker
// Port-level checks of latency and beat ordering for numeric_type_cast.
// ----------------------------------------------------------------------------
module ntc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        last_element_i,
  input logic        result_valid_o,
  input logic        last_out_o
);

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 result_valid_o)
    else $error("accepted beat did not return after four clocks");

  a_noinv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##4 !result_valid_o)
    else $error("result beat without an accepted input");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 (last_out_o == $past(last_element_i, 4)))
    else $error("last mark not carried with its beat");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind numeric_type_cast ntc_checker u_ntc_checker (.*);
